// ===== src/rss_pkg.sv =====
// Types and constants shared by the rectangle subtraction block.
package rss_pkg;

  // Field widths
  localparam int CoordW = 16;
  localparam int DimW   = 15;
  localparam int ExtW   = 18;   // edge sums need one sign bit and a carry
  localparam int NPiece = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [DimW-1:0]   dim_t;
  typedef logic signed [ExtW-1:0]   ext_t;
  typedef logic        [1:0]        cfg_idx_t;
  typedef logic        [CoordW-1:0] cfg_data_t;
  typedef logic        [NPiece-1:0] piece_mask_t;
  typedef logic        [1:0]        slot_t;

  // Configuration register indexes
  localparam cfg_idx_t RegClipLeft   = 2'd0;
  localparam cfg_idx_t RegClipTop    = 2'd1;
  localparam cfg_idx_t RegClipWidth  = 2'd2;
  localparam cfg_idx_t RegClipHeight = 2'd3;

  // Piece slots, emitted in this order
  localparam slot_t SlotTop    = 2'd0;
  localparam slot_t SlotLeft   = 2'd1;
  localparam slot_t SlotRight  = 2'd2;
  localparam slot_t SlotBottom = 2'd3;

  typedef struct packed {
    coord_t left;
    coord_t top;
    dim_t   width;
    dim_t   height;
  } rect_t;

  typedef struct packed {
    rect_t r;
    logic  removed;
  } piece_t;

  // Emitter status back to the input stage
  typedef struct packed {
    logic take;   // input stage item moves into the piece buffer
    logic busy;   // buffer or output register holds something
  } emit_stat_t;

endpackage

// ===== src/rss_if.sv =====
// Channel interfaces: input rectangles, result pieces and configuration writes.
interface rss_rect_if;
  import rss_pkg::*;
  logic   valid;
  logic   ready;
  coord_t rect_left;
  coord_t rect_top;
  dim_t   rect_width;
  dim_t   rect_height;
  modport source (output valid, rect_left, rect_top, rect_width, rect_height,
                  input ready);
  modport sink   (input valid, rect_left, rect_top, rect_width, rect_height,
                  output ready);
endinterface

interface rss_piece_if;
  import rss_pkg::*;
  logic   valid;
  logic   ready;
  coord_t piece_left;
  coord_t piece_top;
  dim_t   piece_width;
  dim_t   piece_height;
  logic   removed;
  logic   last_piece;
  modport source (output valid, piece_left, piece_top, piece_width, piece_height,
                  removed, last_piece, input ready);
  modport sink   (input valid, piece_left, piece_top, piece_width, piece_height,
                  removed, last_piece, output ready);
endinterface

interface rss_cfg_if;
  import rss_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  idx;
  cfg_data_t data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== src/rect_subtract_split_top.sv =====
// Rectangle subtraction: each input rectangle minus the clip rectangle, as up to
// four pieces (top, left band, right band, bottom) with last_piece on the final
// one, or one piece marked removed when fully covered. An accepted rectangle
// is registered, split from there into a piece buffer, and its first piece
// then moves into the output register. The single output register sends one
// piece per cycle while the output is ready; a rectangle yields one to four
// pieces. A new rectangle is accepted every cycle while each one gives a single
// piece and the output is ready, and the next one is taken into the buffer in
// the same cycle that the previous one's last piece leaves it.
// Configuration writes are always ready and must only be made while idle.
module rect_subtract_split_top (
  input  logic         clk,
  input  logic         rst_n,
  rss_rect_if.sink     in_rect,
  rss_piece_if.source  out_piece,
  rss_cfg_if.sink      cfg_wr
);
  import rss_pkg::*;

  rect_t                clip_r;
  logic                 s1_valid_r, s1_valid_nxt;
  rect_t                s1_rect_r;
  piece_t [NPiece-1:0]  s1_pieces;
  piece_mask_t          s1_mask;
  emit_stat_t           stat;
  logic                 in_acc;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.idx)
        RegClipLeft:   clip_r.left   <= coord_t'(cfg_wr.data);
        RegClipTop:    clip_r.top    <= coord_t'(cfg_wr.data);
        RegClipWidth:  clip_r.width  <= cfg_wr.data[DimW-1:0];
        RegClipHeight: clip_r.height <= cfg_wr.data[DimW-1:0];
        default:       clip_r        <= clip_r;
      endcase
    end
  end

  // Input register stage
  assign in_rect.ready = !s1_valid_r || stat.take;
  assign in_acc        = in_rect.valid && in_rect.ready;

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (stat.take ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rect_r <= '{in_rect.rect_left, in_rect.rect_top,
                     in_rect.rect_width, in_rect.rect_height};
    end
  end

  rss_split u_split (
    .rect   (s1_rect_r),
    .clip   (clip_r),
    .pieces (s1_pieces),
    .mask   (s1_mask)
  );

  rss_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_pieces (s1_pieces),
    .s1_mask   (s1_mask),
    .stat      (stat),
    .out_piece (out_piece)
  );

  // A removed result is always a lone, empty piece
  a_removed_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_piece.valid && out_piece.removed |->
      out_piece.last_piece && out_piece.piece_width == '0 &&
      out_piece.piece_height == '0)
    else $error("removed result not a lone empty piece");

  // A waiting input item is never overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !stat.take |=> s1_valid_r && $stable(s1_rect_r))
    else $error("input stage item lost");

  // An item only enters the buffer from a full input stage
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stat.take |-> s1_valid_r)
    else $error("buffer loaded from empty input stage");

  // Anything taken into the buffer keeps the emitter busy next cycle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.take |=> stat.busy)
    else $error("taken item vanished");

endmodule

// ===== src/rss_split.sv =====
// Splits one rectangle against the clip rectangle into up to four pieces.
module rss_split (
  input  rss_pkg::rect_t                     rect,
  input  rss_pkg::rect_t                     clip,
  output rss_pkg::piece_t [rss_pkg::NPiece-1:0] pieces,
  output rss_pkg::piece_mask_t               mask
);
  import rss_pkg::*;

  ext_t x0, y0, x1, y1, cx0, cy0, cx1, cy1;
  ext_t ix0, ix1, iy0, iy1;
  ext_t th, bh, lw, rw, ch;
  logic overlap;
  logic has_top, has_left, has_right, has_bot;

  // Edges at extended width
  always_comb begin
    x0  = ext_t'(rect.left);
    y0  = ext_t'(rect.top);
    x1  = x0 + $signed({3'b000, rect.width});
    y1  = y0 + $signed({3'b000, rect.height});
    cx0 = ext_t'(clip.left);
    cy0 = ext_t'(clip.top);
    cx1 = cx0 + $signed({3'b000, clip.width});
    cy1 = cy0 + $signed({3'b000, clip.height});
  end

  // Intersection and band sizes
  always_comb begin
    ix0 = (x0 > cx0) ? x0 : cx0;
    ix1 = (x1 < cx1) ? x1 : cx1;
    iy0 = (y0 > cy0) ? y0 : cy0;
    iy1 = (y1 < cy1) ? y1 : cy1;
    overlap   = (ix0 < ix1) && (iy0 < iy1);
    th        = iy0 - y0;
    bh        = y1 - iy1;
    lw        = ix0 - x0;
    rw        = x1 - ix1;
    ch        = iy1 - iy0;
    has_top   = iy0 > y0;
    has_left  = ix0 > x0;
    has_right = x1 > ix1;
    has_bot   = y1 > iy1;
  end

  // Piece slots; right and bottom edges wrap into 16 bits
  always_comb begin
    pieces = '0;
    mask   = '0;
    if (!overlap) begin
      pieces[SlotTop].r = rect;
      mask[SlotTop]     = 1'b1;
    end else if (!(has_top || has_left || has_right || has_bot)) begin
      // fully covered
      pieces[SlotTop].removed = 1'b1;
      mask[SlotTop]           = 1'b1;
    end else begin
      pieces[SlotTop].r      = '{rect.left, rect.top, rect.width, th[DimW-1:0]};
      pieces[SlotLeft].r     = '{rect.left, coord_t'(iy0[CoordW-1:0]),
                                 lw[DimW-1:0], ch[DimW-1:0]};
      pieces[SlotRight].r    = '{coord_t'(ix1[CoordW-1:0]), coord_t'(iy0[CoordW-1:0]),
                                 rw[DimW-1:0], ch[DimW-1:0]};
      pieces[SlotBottom].r   = '{rect.left, coord_t'(iy1[CoordW-1:0]),
                                 rect.width, bh[DimW-1:0]};
      mask[SlotTop]    = has_top;
      mask[SlotLeft]   = has_left;
      mask[SlotRight]  = has_right;
      mask[SlotBottom] = has_bot;
    end
  end

endmodule

// ===== src/rss_emit.sv =====
// Piece buffer and output register: sends one piece a cycle in slot order while the output is ready.
module rss_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s1_valid,
  input  rss_pkg::piece_t [rss_pkg::NPiece-1:0] s1_pieces,
  input  rss_pkg::piece_mask_t                s1_mask,
  output rss_pkg::emit_stat_t                 stat,
  rss_piece_if.source                         out_piece
);
  import rss_pkg::*;

  piece_mask_t                buf_mask_r, buf_mask_nxt, mask_after;
  piece_t [NPiece-1:0]        buf_piece_r;
  logic                       out_valid_r, out_valid_nxt;
  piece_t                     out_data_r;
  logic                       out_last_r;
  logic                       out_free, send, take;
  slot_t                      sel;

  // Lowest pending slot goes out first
  always_comb begin
    sel = SlotBottom;
    for (int i = NPiece - 1; i >= 0; i--) begin
      if (buf_mask_r[i]) sel = slot_t'(i);
    end
  end

  // Handshake and buffer bookkeeping
  always_comb begin
    out_free   = !out_valid_r || out_piece.ready;
    send       = out_free && (buf_mask_r != '0);
    mask_after = buf_mask_r;
    if (send) mask_after[sel] = 1'b0;
    take          = s1_valid && (mask_after == '0);
    buf_mask_nxt  = take ? s1_mask : mask_after;
    out_valid_nxt = send ? 1'b1 : (out_piece.ready ? 1'b0 : out_valid_r);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      buf_mask_r  <= buf_mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) buf_piece_r <= s1_pieces;
    if (send) begin
      out_data_r <= buf_piece_r[sel];
      out_last_r <= (mask_after == '0);
    end
  end

  assign stat.take = take;
  assign stat.busy = out_valid_r || (buf_mask_r != '0);

  assign out_piece.valid        = out_valid_r;
  assign out_piece.piece_left   = out_data_r.r.left;
  assign out_piece.piece_top    = out_data_r.r.top;
  assign out_piece.piece_width  = out_data_r.r.width;
  assign out_piece.piece_height = out_data_r.r.height;
  assign out_piece.removed      = out_data_r.removed;
  assign out_piece.last_piece   = out_last_r;

endmodule
